// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file fsq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsq assertion failed");

// Next-cycle implication, disabled during reset.
`define FSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsq assertion failed");

`endif

// ===== hw/rtl/fsq_pkg.sv =====
package fsq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 32;

  localparam int OP_W  = 2;
  localparam int SHARD_W = 16;
  localparam int SEQ_W = 32;
  localparam int TGT_W = 16;
  localparam int STAT_W = 3;
  localparam int OC_W  = 2;
  localparam int OCC_W = 6;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_TAKE   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [OC_W-1:0] OC_OK    = 2'd0;
  localparam logic [OC_W-1:0] OC_FULL  = 2'd1;
  localparam logic [OC_W-1:0] OC_DUP   = 2'd2;
  localparam logic [OC_W-1:0] OC_EMPTY = 2'd3;

  // fail_seq is the major key, shard index breaks ties
  typedef struct packed {
    logic [SEQ_W-1:0]   fail_seq;
    logic [SHARD_W-1:0] shard_index;
  } key_t;

  typedef struct packed {
    logic signed [TGT_W-1:0] target_id;
    logic [STAT_W-1:0]       comp_status;
  } pay_t;

  typedef struct packed {
    key_t key;
    pay_t pay;
  } rec_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic take_en;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/fsq_ifs.sv =====
interface fsq_in_if;
  import fsq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [SHARD_W-1:0]      shard_index;
  logic [SEQ_W-1:0]        fail_seq;
  logic signed [TGT_W-1:0] target_id;
  logic [STAT_W-1:0]       comp_status;

  modport source (output valid, operation, shard_index, fail_seq, target_id, comp_status,
                  input ready);
  modport sink (input valid, operation, shard_index, fail_seq, target_id, comp_status,
                output ready);
endinterface

interface fsq_out_if;
  import fsq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OC_W-1:0]         outcome;
  logic [SHARD_W-1:0]      shard_index_out;
  logic [SEQ_W-1:0]        fail_seq_out;
  logic signed [TGT_W-1:0] target_id_out;
  logic [STAT_W-1:0]       comp_status_out;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, outcome, shard_index_out, fail_seq_out, target_id_out,
                  comp_status_out, occupancy, input ready);
  modport sink (input valid, outcome, shard_index_out, fail_seq_out, target_id_out,
                comp_status_out, occupancy, output ready);
endinterface

// ===== hw/rtl/fsq_cell.sv =====
module fsq_cell (
  input  logic              clk,
  input  fsq_pkg::cell_ctl_t ctl,
  input  logic              valid,
  input  fsq_pkg::rec_t     new_rec,
  input  fsq_pkg::rec_t     left_rec,
  input  fsq_pkg::rec_t     right_rec,
  input  logic              left_g,
  output fsq_pkg::rec_t     rec,
  output logic              g,
  output logic              m
);
  import fsq_pkg::*;

  rec_t rec_r;
  logic g_r;
  logic m_r;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      // g: new key belongs at or before this slot (empty slots count as greater)
      g_r <= !valid || (new_rec.key < rec_r.key);
      m_r <= valid && (new_rec.key.shard_index == rec_r.key.shard_index);
    end
    if (ctl.ins_en && g_r) begin
      rec_r <= left_g ? left_rec : new_rec;
    end else if (ctl.take_en) begin
      rec_r <= right_rec;
    end
  end

  assign rec = rec_r;
  assign g   = g_r;
  assign m   = m_r;

endmodule

// ===== hw/rtl/fsq_chain.sv =====
module fsq_chain #(
  parameter int QUEUE_DEPTH = fsq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  fsq_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]   count,
  input  fsq_pkg::rec_t      new_rec,
  output fsq_pkg::rec_t      head_rec,
  output logic               dup
);
  import fsq_pkg::*;

  rec_t             recs [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] g_vec;
  logic [QUEUE_DEPTH-1:0] m_vec;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    rec_t left_rec;
    rec_t right_rec;
    logic left_g;
    logic valid;

    assign valid = CNT_W'(i) < count;

    if (i == 0) begin : g_head
      assign left_rec = new_rec;
      assign left_g   = 1'b0;
    end else begin : g_body
      assign left_rec = recs[i-1];
      assign left_g   = g_vec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_rec = recs[i];
    end else begin : g_mid
      assign right_rec = recs[i+1];
    end

    fsq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (valid),
      .new_rec   (new_rec),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .left_g    (left_g),
      .rec       (recs[i]),
      .g         (g_vec[i]),
      .m         (m_vec[i])
    );
  end

  assign head_rec = recs[0];
  assign dup      = |m_vec;

endmodule

// ===== hw/rtl/failed_shard_sorted_queue_core.sv =====
// Sorted failed-shard queue built as a row of compare-and-shift cells.
// Each accepted word passes the compare state, then the apply state, which registers
// the result but stalls while an earlier result is held unaccepted. No new word is
// accepted until apply; the cell row's compare and shift/apply stages go in turn.
// Reset (rst_n, synchronous, active low) empties the queue and the output register.
module failed_shard_sorted_queue_core #(
  parameter int QUEUE_DEPTH = fsq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  fsq_in_if.sink    in_ch,
  fsq_out_if.source out_ch
);
  import fsq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY} state_t;

  state_t            state_r;
  logic [OP_W-1:0]   op_r;
  rec_t              in_rec_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  logic              out_valid_r;
  logic [OC_W-1:0]   out_outcome_r;
  rec_t              out_rec_r;
  logic [OCC_W-1:0]  out_occ_r;

  cell_ctl_t         ctl;
  rec_t              head_rec;
  logic              dup;
  logic              commit;
  logic              full;
  logic              empty;
  logic [OC_W-1:0]   outcome_nxt;
  logic              in_fire;

  fsq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (CNT_W)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .count    (count_r),
    .new_rec  (in_rec_r),
    .head_rec (head_rec),
    .dup      (dup)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign full   = (count_r == CNT_FULL);
  assign empty  = (count_r == '0);
  assign commit = (state_r == S_APPLY) && (!out_valid_r || out_ch.ready);

  always_comb begin
    ctl.cmp_en  = (state_r == S_CMP);
    ctl.ins_en  = 1'b0;
    ctl.take_en = 1'b0;
    outcome_nxt = OC_OK;
    count_nxt   = count_r;
    case (op_r)
      OP_INSERT: begin
        if (full) begin
          outcome_nxt = OC_FULL;
        end else if (dup) begin
          outcome_nxt = OC_DUP;
        end else begin
          ctl.ins_en = commit;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      OP_TAKE: begin
        if (empty) begin
          outcome_nxt = OC_EMPTY;
        end else begin
          ctl.take_en = commit;
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r                          <= in_ch.operation;
            in_rec_r.key.fail_seq         <= in_ch.fail_seq;
            in_rec_r.key.shard_index      <= in_ch.shard_index;
            in_rec_r.pay.target_id        <= in_ch.target_id;
            in_rec_r.pay.comp_status      <= in_ch.comp_status;
            state_r                       <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (commit) begin
            count_r       <= count_nxt;
            out_outcome_r <= outcome_nxt;
            out_occ_r     <= OCC_W'(count_nxt);
            out_rec_r     <= (op_r == OP_TAKE && !empty) ? head_rec : '0;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.outcome         = out_outcome_r;
  assign out_ch.shard_index_out = out_rec_r.key.shard_index;
  assign out_ch.fail_seq_out    = out_rec_r.key.fail_seq;
  assign out_ch.target_id_out   = out_rec_r.pay.target_id;
  assign out_ch.comp_status_out = out_rec_r.pay.comp_status;
  assign out_ch.occupancy       = out_occ_r;

endmodule

// ===== hw/rtl/fsq_checker.sv =====
`include "assert_macros.svh"

module fsq_checker #(
  parameter int QUEUE_DEPTH = fsq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fsq_pkg::OC_W-1:0]      outcome,
  input logic [fsq_pkg::SHARD_W-1:0]   shard_index_out,
  input logic [fsq_pkg::SEQ_W-1:0]     fail_seq_out,
  input logic [fsq_pkg::OCC_W-1:0]     occupancy
);
  import fsq_pkg::*;

  localparam int OCC_MAX = (QUEUE_DEPTH < (1 << OCC_W)) ? QUEUE_DEPTH : (1 << OCC_W) - 1;

  // a result, once shown, holds until taken
  `FSQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // one operation in flight: no accept right after an accept
  `FSQ_ASSERT_NXT(a_one_inflight, clk, rst_n, in_valid && in_ready, !in_ready)
  `FSQ_ASSERT_IMP(a_empty_occ, clk, rst_n, out_valid && outcome == OC_EMPTY, occupancy == '0)
  `FSQ_ASSERT_IMP(a_refused_zero, clk, rst_n, out_valid && outcome != OC_OK,
                  shard_index_out == '0 && fail_seq_out == '0)
  `FSQ_ASSERT_IMP(a_occ_bound, clk, rst_n, out_valid, 32'(occupancy) <= 32'(OCC_MAX))

endmodule

bind failed_shard_sorted_queue_core fsq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fsq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .outcome         (out_ch.outcome),
  .shard_index_out (out_ch.shard_index_out),
  .fail_seq_out    (out_ch.fail_seq_out),
  .occupancy       (out_ch.occupancy)
);

// ===== bench/tb_failed_shard_sorted_queue_core.sv =====
module tb_failed_shard_sorted_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fsq_pkg::*;

  localparam int QDEPTH = DEFAULT_QUEUE_DEPTH;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SHOW_LIMIT = 10;
  localparam int RANDOM_OPS = 1600;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER_WORDS = 200;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    key_t            key;
    pay_t            pay;
  } queue_op_t;

  typedef struct packed {
    logic [OC_W-1:0]  outcome;
    rec_t             rec;
    logic [OCC_W-1:0] occupancy;
  } queue_result_t;

  typedef struct {
    queue_op_t     op_word;
    int            reps;
    bit            typed;
    queue_result_t want;
  } opening_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fsq_in_if  in_ch ();
  fsq_out_if out_ch ();

  failed_shard_sorted_queue_core #(.QUEUE_DEPTH(QDEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // sorted record store mirrored from the accepted operations
  rec_t shelf [QDEPTH];
  int   held = 0;
  int   peak_held = 0;

  queue_result_t pending_results [$];
  bit            offer_typed;
  queue_result_t offer_want;

  int ops_taken = 0;
  int words_seen = 0;
  int fail_count = 0;
  int oc_hits [4] = '{0, 0, 0, 0};
  int burst_left = 0;

  function automatic queue_op_t mk_op(logic [OP_W-1:0] o, logic [SHARD_W-1:0] s,
                                      logic [SEQ_W-1:0] f, logic signed [TGT_W-1:0] t,
                                      logic [STAT_W-1:0] c);
    return {o, f, s, t, c};
  endfunction

  function automatic queue_result_t mk_res(logic [OC_W-1:0] oc, logic [SHARD_W-1:0] s,
                                           logic [SEQ_W-1:0] f, logic signed [TGT_W-1:0] t,
                                           logic [STAT_W-1:0] c, logic [OCC_W-1:0] occ);
    return {oc, f, s, t, c, occ};
  endfunction

  function automatic queue_result_t apply_queue_op(queue_op_t op_word);
    queue_result_t r;
    int pos;
    r = '0;
    case (op_word.operation)
      OP_INSERT: begin
        if (held >= QDEPTH) begin
          r.outcome = OC_FULL;
        end else begin
          for (int i = 0; i < held; i++)
            if (shelf[i].key.shard_index == op_word.key.shard_index) r.outcome = OC_DUP;
          if (r.outcome != OC_DUP) begin
            pos = held;
            // lowest slot whose key is above the new one
            for (int i = held - 1; i >= 0; i--)
              if (op_word.key < shelf[i].key) pos = i;
            for (int i = held; i > pos; i--) shelf[i] = shelf[i-1];
            shelf[pos] = {op_word.key, op_word.pay};
            held++;
          end
        end
      end
      OP_TAKE: begin
        if (held == 0) begin
          r.outcome = OC_EMPTY;
        end else begin
          r.rec = shelf[0];
          for (int i = 1; i < held; i++) shelf[i-1] = shelf[i];
          held--;
        end
      end
      OP_CLEAR: held = 0;
      default: ;
    endcase
    r.occupancy = OCC_W'(held);
    if (held > peak_held) peak_held = held;
    return r;
  endfunction

  task automatic offer_op(queue_op_t w, bit typed, queue_result_t want);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= w.operation;
    in_ch.shard_index <= w.key.shard_index;
    in_ch.fail_seq    <= w.key.fail_seq;
    in_ch.target_id   <= w.pay.target_id;
    in_ch.comp_status <= w.pay.comp_status;
    offer_typed       <= typed;
    offer_want        <= want;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // prediction on input accept, comparison on output accept
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t seen;
    queue_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        got = apply_queue_op({in_ch.operation, in_ch.fail_seq, in_ch.shard_index,
                              in_ch.target_id, in_ch.comp_status});
        pending_results.push_back(offer_typed ? offer_want : got);
        ops_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        seen = {out_ch.outcome, out_ch.fail_seq_out, out_ch.shard_index_out,
                out_ch.target_id_out, out_ch.comp_status_out, out_ch.occupancy};
        words_seen++;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("%0t: unexpected word oc=%0d shard=%h seq=%h tgt=%0d st=%0d occ=%0d",
                     $realtime, seen.outcome, seen.rec.key.shard_index, seen.rec.key.fail_seq,
                     seen.rec.pay.target_id, seen.rec.pay.comp_status, seen.occupancy);
        end else begin
          want = pending_results.pop_front();
          oc_hits[want.outcome]++;
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT) begin
              $display("%0t: word %0d mismatch", $realtime, words_seen);
              $display("  exp oc=%0d shard=%h seq=%h tgt=%0d st=%0d occ=%0d",
                       want.outcome, want.rec.key.shard_index, want.rec.key.fail_seq,
                       want.rec.pay.target_id, want.rec.pay.comp_status, want.occupancy);
              $display("  got oc=%0d shard=%h seq=%h tgt=%0d st=%0d occ=%0d",
                       seen.outcome, seen.rec.key.shard_index, seen.rec.key.fail_seq,
                       seen.rec.pay.target_id, seen.rec.pay.comp_status, seen.occupancy);
            end
          end
        end
      end
    end
  end

  // result side: stall pattern plus one long hold-off to back the queue up
  initial begin : result_side
    int hold_left;
    int mode_left;
    int rx_mode;
    int rx_phase;
    bit long_hold_done;
    hold_left = 0;
    mode_left = 0;
    rx_mode = 0;
    rx_phase = 0;
    long_hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rx_phase++;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && words_seen >= HOLD_AFTER_WORDS) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 99) >= 35);
          2: out_ch.ready <= (rx_phase % 5 != 1) && (rx_phase % 5 != 3);
          default: out_ch.ready <= (rx_phase % 7) < 4;
        endcase
      end
    end
  end

  initial begin : stimulus
    opening_row_t opening_rows [$];
    queue_op_t w;
    int seg_left;
    int seg_mode;
    int ins_pct;
    int pick;
    logic [OP_W-1:0] o;
    logic [SHARD_W-1:0] s;
    logic [SEQ_W-1:0] f;
    logic signed [TGT_W-1:0] t;

    in_ch.valid = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.shard_index = '0;
    in_ch.fail_seq = '0;
    in_ch.target_id = '0;
    in_ch.comp_status = '0;
    offer_typed = 1'b0;
    offer_want = '0;
    seg_left = 0;
    seg_mode = 0;

    opening_rows.push_back('{mk_op(OP_TAKE, 0, 0, 0, 0), 1, 1'b1,
                             mk_res(OC_EMPTY, 0, 0, 0, 0, 0)});
    opening_rows.push_back('{mk_op(OP_CLEAR, 0, 0, 0, 0), 1, 1'b1,
                             mk_res(OC_OK, 0, 0, 0, 0, 0)});
    opening_rows.push_back('{mk_op(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, -16'sd1, 3'd7), 1, 1'b1,
                             mk_res(OC_OK, 0, 0, 0, 0, 0)});
    opening_rows.push_back('{mk_op(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, -16'sd1, 3'd7), 1, 1'b1,
                             mk_res(OC_OK, 0, 0, 0, 0, 1)});
    opening_rows.push_back('{mk_op(OP_INSERT, 0, 0, 16'sh7FFF, 0), 1, 1'b1,
                             mk_res(OC_OK, 0, 0, 0, 0, 2)});
    opening_rows.push_back('{mk_op(OP_INSERT, 16'hFFFF, 0, 16'sd5, 3'd3), 1, 1'b1,
                             mk_res(OC_DUP, 0, 0, 0, 0, 2)});
    // same fail_seq, shard index decides
    opening_rows.push_back('{mk_op(OP_INSERT, 16'd1, 0, 16'sd100, 3'd5), 1, 1'b0, '0});
    opening_rows.push_back('{mk_op(OP_INSERT, 16'd2, 32'hFFFF_FFFF, 0, 3'd1), 1, 1'b0, '0});
    opening_rows.push_back('{mk_op(OP_TAKE, 0, 0, 0, 0), 1, 1'b1,
                             mk_res(OC_OK, 0, 0, 16'sh7FFF, 0, 3)});
    opening_rows.push_back('{mk_op(OP_TAKE, 0, 0, 0, 0), 1, 1'b0, '0});
    opening_rows.push_back('{mk_op(OP_UNUSED, 16'h1234, 32'h5678_9ABC, 16'sd77, 3'd2), 1, 1'b1,
                             mk_res(OC_OK, 0, 0, 0, 0, 2)});
    opening_rows.push_back('{mk_op(OP_TAKE, 0, 0, 0, 0), 1, 1'b0, '0});
    opening_rows.push_back('{mk_op(OP_TAKE, 0, 0, 0, 0), 1, 1'b1,
                             mk_res(OC_OK, 16'hFFFF, 32'hFFFF_FFFF, -16'sd1, 3'd7, 0)});
    opening_rows.push_back('{mk_op(OP_TAKE, 0, 0, 0, 0), 1, 1'b1,
                             mk_res(OC_EMPTY, 0, 0, 0, 0, 0)});
    // fill to the brim, each new record lands at the head
    opening_rows.push_back('{mk_op(OP_INSERT, 16'd100, 32'd5000, 16'sd9, 3'd4), QDEPTH, 1'b0,
                             '0});
    opening_rows.push_back('{mk_op(OP_INSERT, 16'd7, 0, 0, 0), 1, 1'b1,
                             mk_res(OC_FULL, 0, 0, 0, 0, 6'(QDEPTH))});
    // full takes precedence over duplicate
    opening_rows.push_back('{mk_op(OP_INSERT, 16'd100, 32'd1, 0, 0), 1, 1'b1,
                             mk_res(OC_FULL, 0, 0, 0, 0, 6'(QDEPTH))});
    opening_rows.push_back('{mk_op(OP_TAKE, 0, 0, 0, 0), 3, 1'b0, '0});
    opening_rows.push_back('{mk_op(OP_INSERT, 16'd101, 32'd1, 16'sd3, 3'd6), 1, 1'b1,
                             mk_res(OC_DUP, 0, 0, 0, 0, 6'(QDEPTH - 3))});
    opening_rows.push_back('{mk_op(OP_INSERT, 16'd9, 32'd4999, 16'sd12, 3'd2), 1, 1'b0, '0});
    opening_rows.push_back('{mk_op(OP_TAKE, 0, 0, 0, 0), 2, 1'b0, '0});
    opening_rows.push_back('{mk_op(OP_CLEAR, 0, 0, 0, 0), 1, 1'b1,
                             mk_res(OC_OK, 0, 0, 0, 0, 0)});
    opening_rows.push_back('{mk_op(OP_TAKE, 0, 0, 0, 0), 1, 1'b1,
                             mk_res(OC_EMPTY, 0, 0, 0, 0, 0)});
    opening_rows.push_back('{mk_op(OP_INSERT, 16'h8000, 32'h8000_0000, 16'sh4000, 3'd2), 1, 1'b1,
                             mk_res(OC_OK, 0, 0, 0, 0, 1)});
    opening_rows.push_back('{mk_op(OP_CLEAR, 0, 0, 0, 0), 1, 1'b1,
                             mk_res(OC_OK, 0, 0, 0, 0, 0)});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[r]) begin
      for (int k = 0; k < opening_rows[r].reps; k++) begin
        w = opening_rows[r].op_word;
        w.key.shard_index += SHARD_W'(k);
        w.key.fail_seq -= SEQ_W'(k);
        offer_op(w, opening_rows[r].typed, opening_rows[r].want);
      end
    end

    // segments lean toward filling, draining or a balanced mix
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(16, 80);
      end
      seg_left--;
      ins_pct = (seg_mode == 0) ? 75 : (seg_mode == 1) ? 25 : 50;
      pick = $urandom_range(0, 99);
      if (pick < 1) o = OP_CLEAR;
      else if (pick < 3) o = OP_UNUSED;
      else if (pick < 3 + ins_pct) o = OP_INSERT;
      else o = OP_TAKE;

      if (held > 0 && $urandom_range(0, 99) < 12)
        s = shelf[$urandom_range(0, held - 1)].key.shard_index;
      else if ($urandom_range(0, 99) < 15)
        s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else
        s = SHARD_W'($urandom_range(0, 65535));

      pick = $urandom_range(0, 99);
      if (pick < 35) f = $urandom_range(0, 3);
      else if (pick < 45) f = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      else if (pick < 55) f = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      else f = $urandom;

      pick = $urandom_range(0, 99);
      if (pick < 12) t = -16'sd1;
      else if (pick < 20) t = 16'sh7FFF;
      else t = TGT_W'($urandom_range(0, 32767));

      offer_op(mk_op(o, s, f, t, STAT_W'($urandom_range(0, 7))), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("%0d operations offered and accepted, %0d result words checked, %0d failures",
             ops_taken, words_seen, fail_count);
    $display("outcomes ok/full/dup/empty: %0d/%0d/%0d/%0d, peak occupancy %0d of %0d",
             oc_hits[OC_OK], oc_hits[OC_FULL], oc_hits[OC_DUP], oc_hits[OC_EMPTY],
             peak_held, QDEPTH);
    if (fail_count == 0) begin
      $display("PASS failed_shard_sorted_queue_core");
    end else begin
      $display("FAIL failed_shard_sorted_queue_core");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAIL failed_shard_sorted_queue_core");
    $finish;
  end

endmodule
